FILE: hdl/upwind_ct_corner_emf_top_assert.svh
// Assertion macros for the upwind corner emf block and its checker.
`ifndef UPWIND_CT_CORNER_EMF_TOP_ASSERT_SVH
`define UPWIND_CT_CORNER_EMF_TOP_ASSERT_SVH

// Plain implication, sampled on the rising clock edge, off during reset.
`define UCCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ucce: implication check failed");

// Implication whose consequent is checked after the delay given by the argument n.
`define UCCE_ASSERT_DLY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##n (cons)) \
        else $error("ucce: delayed check failed");

`endif

FILE: hdl/ucce_pkg.sv
package ucce_pkg;

    // Word width of every signed field; speeds drop the sign bit.
    localparam int UCCE_WORD_BITS  = 32;
    localparam int UCCE_SPEED_BITS = UCCE_WORD_BITS - 1;

    typedef struct packed {
        logic [UCCE_SPEED_BITS-1:0]       speed_minus_first;
        logic [UCCE_SPEED_BITS-1:0]       speed_plus_first;
        logic [UCCE_SPEED_BITS-1:0]       speed_minus_second;
        logic [UCCE_SPEED_BITS-1:0]       speed_plus_second;
        logic signed [UCCE_WORD_BITS-1:0] emf_left_left;
        logic signed [UCCE_WORD_BITS-1:0] emf_right_left;
        logic signed [UCCE_WORD_BITS-1:0] emf_left_right;
        logic signed [UCCE_WORD_BITS-1:0] emf_right_right;
        logic signed [UCCE_WORD_BITS-1:0] field_a_left_left;
        logic signed [UCCE_WORD_BITS-1:0] field_a_right_left;
        logic signed [UCCE_WORD_BITS-1:0] field_b_left_left;
        logic signed [UCCE_WORD_BITS-1:0] field_b_left_right;
    } t_ucce_in;

    typedef struct packed {
        logic signed [UCCE_WORD_BITS-1:0] corner_emf;
        logic                             saturated;
    } t_ucce_out;

    // Quotient bits that every divider produces: enough for the bilinear
    // average and for the largest diffusion term.
    function automatic int ucce_quo_bits(input int frac);
        int q2;
        q2 = 2 * UCCE_WORD_BITS - 2 - frac;
        return (q2 > UCCE_WORD_BITS) ? q2 : UCCE_WORD_BITS;
    endfunction

endpackage

FILE: hdl/ucce_div.sv
module ucce_div #(
    parameter int NW = 96,
    parameter int DW = 64,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    // Restoring division, one quotient bit per stage. The numerator is
    // known to be below den * 2^QW, so the initial remainder is below den.
    logic [NW+QW-1:0] num_ext;
    logic [DW-1:0]    rem_in;
    logic [QW-1:0]    low_in;

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [DW-1:0] r_den [QW];

    assign num_ext = {{QW{1'b0}}, i_num};
    assign rem_in  = DW'(num_ext >> QW);
    assign low_in  = num_ext[QW-1:0];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_i;
        logic [DW-1:0] den_i;
        logic [QW-1:0] low_i;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_i = rem_in;
            assign low_i = low_in;
            assign den_i = i_den;
        end else begin : g_next
            assign rem_i = r_rem[k-1];
            assign low_i = r_low[k-1];
            assign den_i = r_den[k-1];
        end

        assign trial = {rem_i, low_i[QW-1]};
        assign diff  = trial - {1'b0, den_i};
        assign ge    = !diff[DW];

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_low[k] <= {low_i[QW-2:0], ge};
            r_den[k] <= den_i;
        end
    end

    assign o_quo = r_low[QW-1];

endmodule

FILE: hdl/upwind_ct_corner_emf_top.sv
// Upwind constrained-transport corner emf, fully pipelined.
// The result passes the input register, the product and sum stages, the dividers and
// the final stages; QW = max(32, 62 - FRAC_BITS) is the divider quotient width.
// Throughput: one item per cycle, set by the one-bit-per-stage dividers.
// The receiver cannot stall, so busy is high only while reset is held.
// Reset is synchronous and active low; it clears every valid bit in flight.
module upwind_ct_corner_emf_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  ucce_pkg::t_ucce_in  i_item,
    output logic                busy,
    output logic                o_strobe,
    output ucce_pkg::t_ucce_out o_result
);
    import ucce_pkg::*;

    // Widths. Speeds are W-1 bits, speed products PW bits, field jumps DFW
    // bits signed. Every full product and every sum fits XW signed bits,
    // and every magnitude fits NW bits.
    localparam int W   = UCCE_WORD_BITS;
    localparam int SW  = W - 1;
    localparam int PW  = 2 * W - 2;
    localparam int DFW = W + 1;
    localparam int XW  = 3 * W + 1;
    localparam int NW  = 3 * W;
    localparam int DW1 = 2 * W;
    localparam int QW  = ucce_quo_bits(FRAC_BITS);
    localparam int RW  = QW + 3;

    localparam logic signed [RW-1:0] RES_MAX = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [RW-1:0] RES_MIN = {{(RW-W+1){1'b1}}, {(W-1){1'b0}}};

    // Every item is taken on its start edge; only reset holds items off.
    assign busy = !i_rst_n;

    // Stage 0: input register.
    logic     r_v0;
    t_ucce_in r_in0;

    // Stage 1: speed products, speed sums and field jumps. The four corner
    // weights are kept in the order left-left, right-left, left-right,
    // right-right, matching the emf array.
    logic                  r_v1;
    logic [PW-1:0]         r_w1  [4];
    logic [PW-1:0]         r_wa1;
    logic [PW-1:0]         r_wb1;
    logic [W-1:0]          r_s1a;
    logic [W-1:0]          r_s1b;
    logic signed [DFW-1:0] r_da1;
    logic signed [DFW-1:0] r_db1;
    logic signed [W-1:0]   r_e1  [4];

    // Stage 2: each weight is split in two halves of SW bits, and each half
    // is multiplied on its own; the denominator of the average is formed.
    logic                  r_v2;
    logic signed [2*W-1:0] r_pl2 [4];
    logic signed [2*W-1:0] r_ph2 [4];
    logic signed [2*W:0]   r_qal2;
    logic signed [2*W:0]   r_qah2;
    logic signed [2*W:0]   r_qbl2;
    logic signed [2*W:0]   r_qbh2;
    logic [DW1-1:0]        r_d2;
    logic [W-1:0]          r_s2a;
    logic [W-1:0]          r_s2b;

    // Stage 3: the halves are joined. A zero divisor is replaced by one;
    // its numerator is then zero as well, so the term comes out as zero.
    logic                 r_v3;
    logic signed [XW-1:0] r_p3 [4];
    logic signed [XW-1:0] r_pa3;
    logic signed [XW-1:0] r_pb3;
    logic [DW1-1:0]       r_d3;
    logic [W-1:0]         r_s3a;
    logic [W-1:0]         r_s3b;

    // Stages 4 and 5: the four weighted emfs are summed as a tree.
    logic                 r_v4;
    logic signed [XW-1:0] r_acca4;
    logic signed [XW-1:0] r_accb4;
    logic signed [XW-1:0] r_pa4;
    logic signed [XW-1:0] r_pb4;
    logic [DW1-1:0]       r_d4;
    logic [W-1:0]         r_s4a;
    logic [W-1:0]         r_s4b;

    logic                 r_v5;
    logic signed [XW-1:0] r_acc5;
    logic signed [XW-1:0] r_pa5;
    logic signed [XW-1:0] r_pb5;
    logic [DW1-1:0]       r_d5;
    logic [W-1:0]         r_s5a;
    logic [W-1:0]         r_s5b;

    // Stage 6: sign and magnitude for the dividers. Dividing the diffusion
    // numerator by the speed sum shifted up by FRAC_BITS equals shifting the
    // magnitude down first and then dividing by the speed sum alone.
    logic           r_v6;
    logic [NW-1:0]  r_m6 [3];
    logic [2:0]     r_sg6;
    logic [DW1-1:0] r_d6;
    logic [W-1:0]   r_s6a;
    logic [W-1:0]   r_s6b;

    // Divider stages: the signs and valid bits travel alongside.
    logic          r_vd  [QW];
    logic [2:0]    r_sgd [QW];
    logic [QW-1:0] quo   [3];

    // Final stages: restore signs, add the first two terms, subtract the third, saturate.
    logic                 r_vf1;
    logic signed [QW:0]   r_t [3];
    logic                 r_vf2;
    logic signed [RW-1:0] r_res;

    logic                 n_sat;
    logic signed [W-1:0]  n_emf;

    // The three divisions run in lockstep so that their results line up.
    ucce_div #(.NW(NW), .DW(DW1), .QW(QW)) u_div_avg (
        .i_clk (i_clk),
        .i_num (r_m6[0]),
        .i_den (r_d6),
        .o_quo (quo[0])
    );

    ucce_div #(.NW(NW), .DW(W), .QW(QW)) u_div_a (
        .i_clk (i_clk),
        .i_num (r_m6[1]),
        .i_den (r_s6a),
        .o_quo (quo[1])
    );

    ucce_div #(.NW(NW), .DW(W), .QW(QW)) u_div_b (
        .i_clk (i_clk),
        .i_num (r_m6[2]),
        .i_den (r_s6b),
        .o_quo (quo[2])
    );

    // Saturation of the summed result to the word range.
    always_comb begin
        if (r_res > RES_MAX) begin
            n_sat = 1'b1;
            n_emf = {1'b0, {(W-1){1'b1}}};
        end else if (r_res < RES_MIN) begin
            n_sat = 1'b1;
            n_emf = {1'b1, {(W-1){1'b0}}};
        end else begin
            n_sat = 1'b0;
            n_emf = r_res[W-1:0];
        end
    end

    // Valid bits: the only state that reset touches.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_v6     <= 1'b0;
            for (int k = 0; k < QW; k++) begin
                r_vd[k] <= 1'b0;
            end
            r_vf1    <= 1'b0;
            r_vf2    <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_v0     <= start;
            r_v1     <= r_v0;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_v5     <= r_v4;
            r_v6     <= r_v5;
            r_vd[0]  <= r_v6;
            for (int k = 1; k < QW; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            r_vf1    <= r_vd[QW-1];
            r_vf2    <= r_vf1;
            o_strobe <= r_vf2;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_in0 <= i_item;

        r_w1[0] <= PW'(r_in0.speed_minus_first) * PW'(r_in0.speed_minus_second);
        r_w1[1] <= PW'(r_in0.speed_plus_first) * PW'(r_in0.speed_minus_second);
        r_w1[2] <= PW'(r_in0.speed_minus_first) * PW'(r_in0.speed_plus_second);
        r_w1[3] <= PW'(r_in0.speed_plus_first) * PW'(r_in0.speed_plus_second);
        r_wa1   <= PW'(r_in0.speed_minus_first) * PW'(r_in0.speed_plus_first);
        r_wb1   <= PW'(r_in0.speed_minus_second) * PW'(r_in0.speed_plus_second);
        r_s1a   <= W'(r_in0.speed_minus_first) + W'(r_in0.speed_plus_first);
        r_s1b   <= W'(r_in0.speed_minus_second) + W'(r_in0.speed_plus_second);
        r_da1   <= DFW'(r_in0.field_a_left_left) - DFW'(r_in0.field_a_right_left);
        r_db1   <= DFW'(r_in0.field_b_left_left) - DFW'(r_in0.field_b_left_right);
        r_e1[0] <= r_in0.emf_left_left;
        r_e1[1] <= r_in0.emf_right_left;
        r_e1[2] <= r_in0.emf_left_right;
        r_e1[3] <= r_in0.emf_right_right;

        for (int k = 0; k < 4; k++) begin
            r_pl2[k] <= $signed({1'b0, r_w1[k][SW-1:0]}) * r_e1[k];
            r_ph2[k] <= $signed({1'b0, r_w1[k][PW-1:SW]}) * r_e1[k];
        end
        r_qal2 <= $signed({1'b0, r_wa1[SW-1:0]}) * r_da1;
        r_qah2 <= $signed({1'b0, r_wa1[PW-1:SW]}) * r_da1;
        r_qbl2 <= $signed({1'b0, r_wb1[SW-1:0]}) * r_db1;
        r_qbh2 <= $signed({1'b0, r_wb1[PW-1:SW]}) * r_db1;
        r_d2   <= DW1'(r_s1a) * DW1'(r_s1b);
        r_s2a  <= r_s1a;
        r_s2b  <= r_s1b;

        for (int k = 0; k < 4; k++) begin
            r_p3[k] <= (XW'(r_ph2[k]) <<< SW) + XW'(r_pl2[k]);
        end
        r_pa3 <= (XW'(r_qah2) <<< SW) + XW'(r_qal2);
        r_pb3 <= (XW'(r_qbh2) <<< SW) + XW'(r_qbl2);
        r_d3  <= (r_d2 == '0) ? DW1'(1) : r_d2;
        r_s3a <= (r_s2a == '0) ? W'(1) : r_s2a;
        r_s3b <= (r_s2b == '0) ? W'(1) : r_s2b;

        r_acca4 <= r_p3[0] + r_p3[1];
        r_accb4 <= r_p3[2] + r_p3[3];
        r_pa4   <= r_pa3;
        r_pb4   <= r_pb3;
        r_d4    <= r_d3;
        r_s4a   <= r_s3a;
        r_s4b   <= r_s3b;

        r_acc5 <= r_acca4 + r_accb4;
        r_pa5  <= r_pa4;
        r_pb5  <= r_pb4;
        r_d5   <= r_d4;
        r_s5a  <= r_s4a;
        r_s5b  <= r_s4b;

        r_m6[0] <= NW'(r_acc5[XW-1] ? -r_acc5 : r_acc5);
        r_m6[1] <= NW'(r_pa5[XW-1] ? -r_pa5 : r_pa5) >> FRAC_BITS;
        r_m6[2] <= NW'(r_pb5[XW-1] ? -r_pb5 : r_pb5) >> FRAC_BITS;
        r_sg6   <= {r_pb5[XW-1], r_pa5[XW-1], r_acc5[XW-1]};
        r_d6    <= r_d5;
        r_s6a   <= r_s5a;
        r_s6b   <= r_s5b;

        r_sgd[0] <= r_sg6;
        for (int k = 1; k < QW; k++) begin
            r_sgd[k] <= r_sgd[k-1];
        end

        // Each quotient was truncated toward zero on its magnitude.
        for (int k = 0; k < 3; k++) begin
            r_t[k] <= r_sgd[QW-1][k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
        end

        r_res <= RW'(r_t[0]) + RW'(r_t[1]) - RW'(r_t[2]);

        o_result.corner_emf <= n_emf;
        o_result.saturated  <= n_sat;
    end

endmodule

FILE: hdl/ucce_chk.sv
`include "upwind_ct_corner_emf_top_assert.svh"

module ucce_chk #(
    parameter int FRAC_BITS = 16
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input ucce_pkg::t_ucce_out o_result
);
    import ucce_pkg::*;

    localparam int W   = UCCE_WORD_BITS;
    localparam int LAT = ucce_quo_bits(FRAC_BITS) + 10;

    localparam logic signed [W-1:0] EMF_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] EMF_MIN = {1'b1, {(W-1){1'b0}}};

    logic at_limit;

    assign at_limit = (o_result.corner_emf == EMF_MAX) || (o_result.corner_emf == EMF_MIN);

    // Every accepted item yields its result after the fixed latency.
    `UCCE_ASSERT_DLY(a_item_gives_result, start && !busy, LAT, o_strobe)

    // No result without an item accepted the same latency earlier.
    `UCCE_ASSERT_IMP(a_result_had_item, o_strobe, $past(start, LAT) && !$past(busy, LAT))

    // A clipped result sits at one end of the word range.
    `UCCE_ASSERT_IMP(a_sat_at_limit, o_strobe && o_result.saturated, at_limit)

endmodule

bind upwind_ct_corner_emf_top ucce_chk #(.FRAC_BITS(FRAC_BITS)) u_ucce_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
